// ===== sv/dltq_pkg.sv =====
package dltq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 8;
  localparam int DELAY_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK = 2'd0,
    FN_ENQ  = 2'd1,
    FN_DEQ  = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_SH,
    S_INS_WR,
    S_DWALK,
    S_TICK_EV,
    S_DEL_SH
  } state_t;

endpackage

// ===== sv/delta_list_timer_queue.sv =====
// Delta-list timer queue.
// Input: a command is taken on a rising edge with start high and busy low:
//   in_func (tick, enqueue, dequeue), in_timer_id, in_delay_ticks.
// Output: exactly one result per command, shown for one cycle with
//   out_valid high: out_status, out_expired, out_expired_id. The receiver
//   cannot stall; the result must be taken in the cycle it appears.
// Entries sit in a single-port-write, single-port-read array, walked and
// shifted one entry per cycle by a small sequencer around one 33-bit
// add/subtract unit. Per command:
//   tick on empty list, full enqueue, dequeue on empty list, unused code: result in the next cycle.
//   tick without expiry: busy in S_TICK_EV only.
//   tick with expiry: busy in S_TICK_EV, then S_DEL_SH shifting the tail down.
//   enqueue: busy in walk, shift up, write; walk only when appending.
//   dequeue: busy in walk, shift down.
// The result strobe may come before busy drops; the next command waits for
// busy low. The registered array read sets the walk rate.
// Reset empties the list at once; no clearing pass.
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ID_W-1:0]     in_timer_id,
  input  logic [DELAY_W-1:0]  in_delay_ticks,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_expired,
  output logic [ID_W-1:0]     out_expired_id
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  logic [KEY_W-1:0]   mem_id [DEPTH];
  logic [DELAY_W-1:0] mem_dl [DEPTH];
  logic [KEY_W-1:0]   rd_id_r;
  logic [DELAY_W-1:0] rd_dl_r;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      sh_r, sh_nxt;
  logic               merge_r, merge_nxt;
  logic [DELAY_W-1:0] rem_r, rem_nxt;
  logic [DELAY_W-1:0] hold_r, hold_nxt;
  logic [KEY_W-1:0]   id_r, id_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic               out_expired_r, out_expired_nxt;
  logic [ID_W-1:0]    out_expired_id_r, out_expired_id_nxt;

  logic [CW-1:0]      ra_c, wa_c;
  logic               we_c;
  logic [KEY_W-1:0]   wid_c;
  logic [DELAY_W-1:0] wdl_c;

  logic [DELAY_W-1:0] alu_a, alu_b;
  logic               alu_sub;
  logic [DELAY_W:0]   alu_sum;
  logic [DELAY_W-1:0] alu_res;
  logic               alu_cy;

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem_id[wa_c[AW-1:0]] <= wid_c;
      mem_dl[wa_c[AW-1:0]] <= wdl_c;
    end
    rd_id_r <= mem_id[ra_c[AW-1:0]];
    rd_dl_r <= mem_dl[ra_c[AW-1:0]];
  end

  always_comb begin
    alu_a   = rem_r;
    alu_b   = rd_dl_r;
    alu_sub = 1'b1;
    case (state_r)
      S_WALK: begin
        alu_a = rem_r;
        alu_b = rd_dl_r;
      end
      S_INS_SH: begin
        alu_a = rd_dl_r;
        alu_b = rem_r;
      end
      S_TICK_EV: begin
        alu_a = rd_dl_r;
        alu_b = DELAY_W'(1);
      end
      S_DEL_SH: begin
        alu_a   = rd_dl_r;
        alu_b   = hold_r;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = rem_r;
        alu_b = rd_dl_r;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{DELAY_W{1'b0}}, alu_sub};
  assign alu_res = alu_sum[DELAY_W-1:0];
  assign alu_cy  = alu_sum[DELAY_W];

  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    pos_nxt            = pos_r;
    sh_nxt             = sh_r;
    merge_nxt          = merge_r;
    rem_nxt            = rem_r;
    hold_nxt           = hold_r;
    id_nxt             = id_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_expired_nxt    = out_expired_r;
    out_expired_id_nxt = out_expired_id_r;
    ra_c               = '0;
    wa_c               = '0;
    we_c               = 1'b0;
    wid_c              = id_r;
    wdl_c              = rem_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt          = in_timer_id[KEY_W-1:0];
          rem_nxt         = in_delay_ticks;
          pos_nxt         = '0;
          out_status_nxt  = STS_OK;
          out_expired_nxt = 1'b0;
          out_expired_id_nxt = '0;
          case (in_func)
            FN_TICK: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_TICK_EV;
              end
            end
            FN_ENQ: begin
              if (cnt_r == CW'(DEPTH)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_FULL;
              end else begin
                state_nxt = S_WALK;
              end
            end
            FN_DEQ: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_NOT_FOUND;
              end else begin
                state_nxt = S_DWALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        if (pos_r == cnt_r) begin
          we_c           = 1'b1;
          wa_c           = pos_r;
          cnt_nxt        = cnt_r + CW'(1);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (alu_cy) begin
          rem_nxt = alu_res;
          pos_nxt = pos_r + CW'(1);
          ra_c    = pos_r + CW'(1);
        end else begin
          sh_nxt    = cnt_r - CW'(1);
          ra_c      = cnt_r - CW'(1);
          state_nxt = S_INS_SH;
        end
      end

      S_INS_SH: begin
        we_c  = 1'b1;
        wa_c  = sh_r + CW'(1);
        wid_c = rd_id_r;
        wdl_c = rd_dl_r;
        if (sh_r == pos_r) begin
          wdl_c     = alu_res;
          state_nxt = S_INS_WR;
        end else begin
          sh_nxt = sh_r - CW'(1);
          ra_c   = sh_r - CW'(1);
        end
      end

      S_INS_WR: begin
        we_c          = 1'b1;
        wa_c          = pos_r;
        cnt_nxt       = cnt_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_DWALK: begin
        if (rd_id_r == id_r) begin
          out_valid_nxt = 1'b1;
          hold_nxt      = rd_dl_r;
          merge_nxt     = 1'b1;
          if (pos_r + CW'(1) == cnt_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_IDLE;
          end else begin
            sh_nxt    = pos_r + CW'(1);
            ra_c      = pos_r + CW'(1);
            state_nxt = S_DEL_SH;
          end
        end else if (pos_r + CW'(1) == cnt_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          pos_nxt = pos_r + CW'(1);
          ra_c    = pos_r + CW'(1);
        end
      end

      S_TICK_EV: begin
        if (rd_dl_r != '0 && alu_res != '0) begin
          we_c          = 1'b1;
          wa_c          = '0;
          wid_c         = rd_id_r;
          wdl_c         = alu_res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          out_valid_nxt      = 1'b1;
          out_expired_nxt    = 1'b1;
          out_expired_id_nxt = ID_W'(rd_id_r);
          if (cnt_r == CW'(1)) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            merge_nxt = 1'b0;
            pos_nxt   = '0;
            sh_nxt    = CW'(1);
            ra_c      = CW'(1);
            state_nxt = S_DEL_SH;
          end
        end
      end

      S_DEL_SH: begin
        we_c  = 1'b1;
        wa_c  = sh_r - CW'(1);
        wid_c = rd_id_r;
        wdl_c = rd_dl_r;
        if (merge_r && (sh_r - CW'(1) == pos_r)) begin
          wdl_c = alu_cy ? '1 : alu_res;
        end
        if (sh_r + CW'(1) == cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_IDLE;
        end else begin
          sh_nxt = sh_r + CW'(1);
          ra_c   = sh_r + CW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      merge_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      merge_r     <= merge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r            <= pos_nxt;
    sh_r             <= sh_nxt;
    rem_r            <= rem_nxt;
    hold_r           <= hold_nxt;
    id_r             <= id_nxt;
    out_status_r     <= out_status_nxt;
    out_expired_r    <= out_expired_nxt;
    out_expired_id_r <= out_expired_id_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_expired    = out_expired_r;
  assign out_expired_id = out_expired_id_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == $past(cnt_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command in progress");

  a_expire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_expired_r) |-> out_status_r == STS_OK)
    else $error("expiry with non-ok status");

  a_idle_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR) |=> (state_r == S_IDLE && out_valid_r))
    else $error("insert write did not complete the enqueue");

endmodule

// ===== tb/timer_queue_checker.sv =====
module timer_queue_checker
  import dltq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ID_W-1:0]     in_timer_id,
  input  logic [DELAY_W-1:0]  in_delay_ticks,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic                out_expired,
  input  logic [ID_W-1:0]     out_expired_id,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                expired;
    logic [ID_W-1:0]     expired_id;
  } timer_result_t;

  logic [ID_W-1:0]    list_id    [DEPTH_DEF];
  logic [DELAY_W-1:0] list_delta [DEPTH_DEF];
  int                 list_count;
  timer_result_t      due_results[$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fail_count < 100)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one command to the delta list and return the result it yields.
  function automatic timer_result_t timer_outcome(input logic [FUNC_W-1:0] fn,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [DELAY_W-1:0] dly);
    timer_result_t      res;
    int                 pos;
    logic [DELAY_W-1:0] rest;
    logic [DELAY_W:0]   sum;
    res.status     = STS_OK;
    res.expired    = 1'b0;
    res.expired_id = '0;
    rest           = dly;
    pos            = 0;
    case (fn)
      FN_TICK: begin
        if (list_count != 0) begin
          if (list_delta[0] != 0)
            list_delta[0] = list_delta[0] - 1;
          if (list_delta[0] == 0) begin
            res.expired    = 1'b1;
            res.expired_id = list_id[0];
            for (int k = 0; k + 1 < list_count; k++) begin
              list_id[k]    = list_id[k + 1];
              list_delta[k] = list_delta[k + 1];
            end
            list_count--;
          end
        end
      end
      FN_ENQ: begin
        if (list_count >= DEPTH_DEF) begin
          res.status = STS_FULL;
        end else begin
          while (pos < list_count && list_delta[pos] <= rest) begin
            rest = rest - list_delta[pos];
            pos++;
          end
          if (pos < list_count)
            list_delta[pos] = list_delta[pos] - rest;
          for (int k = list_count; k > pos; k--) begin
            list_id[k]    = list_id[k - 1];
            list_delta[k] = list_delta[k - 1];
          end
          list_id[pos]    = id;
          list_delta[pos] = rest;
          list_count++;
        end
      end
      FN_DEQ: begin
        while (pos < list_count && list_id[pos] != id)
          pos++;
        if (pos >= list_count) begin
          res.status = STS_NOT_FOUND;
        end else begin
          // fold the removed delta into the successor, saturating
          if (pos + 1 < list_count) begin
            sum = {1'b0, list_delta[pos + 1]} + {1'b0, list_delta[pos]};
            list_delta[pos + 1] = sum[DELAY_W] ? '1 : sum[DELAY_W-1:0];
          end
          for (int k = pos; k + 1 < list_count; k++) begin
            list_id[k]    = list_id[k + 1];
            list_delta[k] = list_delta[k + 1];
          end
          list_count--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t want;
    if (!rst_n) begin
      list_count = 0;
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          flag_mismatch("result with nothing pending, status", 32'(out_status), '0);
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_expired !== want.expired)
            flag_mismatch("expired", 32'(out_expired), 32'(want.expired));
          if (out_expired_id !== want.expired_id)
            flag_mismatch("expired_id", 32'(out_expired_id), 32'(want.expired_id));
        end
      end
      if (start && !busy)
        due_results.push_back(timer_outcome(in_func, in_timer_id, in_delay_ticks));
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench
  import dltq_pkg::*;
;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 430;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [ID_W-1:0]     in_timer_id;
  logic [DELAY_W-1:0]  in_delay_ticks;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_expired;
  logic [ID_W-1:0]     out_expired_id;
  int                  fail_count;
  int                  pending;
  int                  idle_pct;

  delta_list_timer_queue DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_timer_id    (in_timer_id),
    .in_delay_ticks (in_delay_ticks),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_expired    (out_expired),
    .out_expired_id (out_expired_id)
  );

  timer_queue_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_timer_id    (in_timer_id),
    .in_delay_ticks (in_delay_ticks),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_expired    (out_expired),
    .out_expired_id (out_expired_id),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Present one command and hold it until the block takes it.
  task automatic issue_command(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                               input logic [DELAY_W-1:0] dly);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start          = 1'b1;
    in_func        = fn;
    in_timer_id    = id;
    in_delay_ticks = dly;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned spread;
    logic [FUNC_W-1:0]  fn;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] dly;
    bit                 filling;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = FN_TICK;
    in_timer_id    = '0;
    in_delay_ticks = '0;
    idle_pct       = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list, unused code, dequeue on empty list, expiry on zero delay
    issue_command(FN_TICK, 8'h00, 32'h0);
    issue_command(FN_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    issue_command(FN_DEQ, 8'h42, 32'h0);
    issue_command(FN_ENQ, 8'h00, 32'h0);
    issue_command(FN_TICK, 8'h00, 32'h0);
    // fill to capacity with extremes, a duplicate and a zero delay, then a full enqueue, dequeues and a tick
    issue_command(FN_ENQ, 8'hFF, 32'hFFFF_FFFF);
    issue_command(FN_ENQ, 8'hAA, 32'd1);
    issue_command(FN_ENQ, 8'h55, 32'd3);
    issue_command(FN_ENQ, 8'hAA, 32'd2);
    issue_command(FN_ENQ, 8'h01, 32'd0);
    for (int k = 0; k < 11; k++)
      issue_command(FN_ENQ, ID_W'(8'h20 + k), DELAY_W'(k * 7));
    issue_command(FN_ENQ, 8'h77, 32'd5);
    issue_command(FN_DEQ, 8'hAA, 32'h0);
    issue_command(FN_DEQ, 8'h99, 32'h0);
    issue_command(FN_TICK, 8'h00, 32'h0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 57 : 14;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate runs that fill the list and runs that drain it
        filling = ((n / 40) % 2) == 0;
        pick    = $urandom_range(99);
        if (pick < (filling ? 55 : 20))
          fn = FN_ENQ;
        else if (pick < 80)
          fn = FN_TICK;
        else if (pick < (filling ? 97 : 95))
          fn = FN_DEQ;
        else
          fn = FN_UNUSED;
        id     = ($urandom_range(99) < 75) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
        spread = $urandom_range(99);
        if (fn != FN_ENQ || spread >= 95)
          dly = $urandom;
        else if (spread < 60)
          dly = $urandom_range(6);
        else if (spread < 85)
          dly = $urandom_range(40);
        else
          dly = $urandom_range(2000);
        issue_command(fn, id, dly);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid)
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
